/* sv/assert_macros.svh */
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("implication check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("next-cycle check failed");

`endif

/* sv/pltiu_pkg.sv */
package pltiu_pkg;

	// operation codes of an input item
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LAST_RD,
		ST_LAST_CHK,
		ST_FIRST_RD,
		ST_FIRST_CHK,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_YA_RD,
		ST_YB_RD,
		ST_EVAL,
		ST_MUL,
		ST_DIV_INIT,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic wr;
		logic cap_q;
		logic ld_xa;
		logic ld_xb;
		logic ld_ya;
		logic prep;
		logic mul;
		logic div_init;
		logic div_step;
		logic res_none;
		logic res_eq;
		logic res_interp;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic q_gt_rd;
		logic q_lt_rd;
		logic q_ge_xa;
		logic x_eq;
		logic ya_ok;
		logic yb_ok;
	} sts_t;

endpackage

/* sv/piecewise_linear_table_interp_unit.sv */
// Channel | Direction | Handshake             | Payload
// cfg     | in        | cfg_wr_en             | cfg_wr_data (points_in_use)
// in      | in        | in_valid / in_ready   | operation, knot_index, x_value, y_value, y_valid
// out     | out       | out_valid / out_ready | found, y_result, y_result_valid
//
// A write item gives no result.
// A query scans for the bracketing segment: the scan reads one knot at a time on the
// single memory read port, then, for an interpolated result, a 33-step divide runs.
// One item is in flight at a time; in_ready stays low until the result is taken.
// Reset clears control and the count register; knot memories are not cleared.
module piecewise_linear_table_interp_unit #(
	parameter int TABLE_DEPTH = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [8:0]                    cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [7:0]                    knot_index,
	input  logic signed [VALUE_WIDTH-1:0] x_value,
	input  logic signed [VALUE_WIDTH-1:0] y_value,
	input  logic                          y_valid,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic signed [VALUE_WIDTH-1:0] y_result,
	output logic                          y_result_valid
);
	import pltiu_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [8:0]    points_q;
	cmd_t          cmd;
	sts_t          sts;
	logic [AW-1:0] rd_addr;

	// count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) points_q <= '0;
		else if (cfg_wr_en) points_q <= cfg_wr_data;
	end

	pltiu_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.points_in_use(points_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.knot_index   (knot_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sts          (sts),
		.cmd          (cmd),
		.rd_addr      (rd_addr)
	);

	pltiu_dpath #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dpath (
		.clk           (clk),
		.cmd           (cmd),
		.rd_addr       (rd_addr),
		.knot_index    (knot_index),
		.x_value       (x_value),
		.y_value       (y_value),
		.y_valid       (y_valid),
		.sts           (sts),
		.found         (found),
		.y_result      (y_result),
		.y_result_valid(y_result_valid)
	);

endmodule

/* sv/pltiu_dpath.sv */
module pltiu_dpath #(
	parameter int TABLE_DEPTH = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                             clk,
	input  pltiu_pkg::cmd_t                  cmd,
	input  logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
	input  logic [7:0]                       knot_index,
	input  logic signed [VALUE_WIDTH-1:0]    x_value,
	input  logic signed [VALUE_WIDTH-1:0]    y_value,
	input  logic                             y_valid,
	output pltiu_pkg::sts_t                  sts,
	output logic                             found,
	output logic signed [VALUE_WIDTH-1:0]    y_result,
	output logic                             y_result_valid
);
	import pltiu_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int VW = VALUE_WIDTH;
	localparam int PW = 2 * VW + 1;

	logic [VW-1:0] x_mem [TABLE_DEPTH];
	logic [VW:0]   y_mem [TABLE_DEPTH];
	logic [VW-1:0] x_rd_q;
	logic [VW:0]   y_rd_q;

	logic [VW-1:0] qv_q, xa_q, xb_q;
	logic [VW:0]   ya_q;
	logic [VW-1:0] ofs_q, dx_q;
	logic [VW:0]   mag_q;
	logic          neg_q;
	logic [PW-1:0] prod_q;
	logic [VW-1:0] rem_q;
	logic [VW:0]   sh_q, quot_q;

	logic [VW:0]   dy;
	logic [VW:0]   trial;
	logic          take;

	// knot memories, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			x_mem[AW'(knot_index)] <= x_value;
			y_mem[AW'(knot_index)] <= {y_valid, y_value};
		end
		x_rd_q <= x_mem[rd_addr];
		y_rd_q <= y_mem[rd_addr];
	end

	// compares for the segment search
	always_comb begin
		sts.q_gt_rd = $signed(qv_q) > $signed(x_rd_q);
		sts.q_lt_rd = $signed(qv_q) < $signed(x_rd_q);
		sts.q_ge_xa = $signed(qv_q) >= $signed(xa_q);
		sts.x_eq    = xa_q == xb_q;
		sts.ya_ok   = ya_q[VW];
		sts.yb_ok   = y_rd_q[VW];
	end

	// slope terms: y[i+1] is on the read port during prep
	assign dy = {y_rd_q[VW-1], y_rd_q[VW-1:0]} - {ya_q[VW-1], ya_q[VW-1:0]};

	// restoring divide step
	assign trial = {rem_q, sh_q[VW]};
	assign take  = trial >= {1'b0, dx_q};

	always_ff @(posedge clk) begin
		if (cmd.cap_q) qv_q <= x_value;
		if (cmd.ld_xa) xa_q <= x_rd_q;
		if (cmd.ld_xb) xb_q <= x_rd_q;
		if (cmd.ld_ya) ya_q <= y_rd_q;
		if (cmd.prep) begin
			ofs_q <= qv_q - xa_q;
			dx_q  <= xb_q - xa_q;
			neg_q <= dy[VW];
			mag_q <= dy[VW] ? (~dy + 1'b1) : dy;
		end
		if (cmd.mul)
			prod_q <= {{(VW + 1){1'b0}}, ofs_q} * {{VW{1'b0}}, mag_q};
		// quotient fits in VW+1 bits since offset <= span
		if (cmd.div_init) begin
			rem_q  <= prod_q[PW-1:VW+1];
			sh_q   <= prod_q[VW:0];
			quot_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= take ? VW'(trial - {1'b0, dx_q}) : trial[VW-1:0];
			sh_q   <= {sh_q[VW-1:0], 1'b0};
			quot_q <= {quot_q[VW-1:0], take};
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.res_none) begin
			found          <= 1'b0;
			y_result       <= '0;
			y_result_valid <= 1'b0;
		end
		if (cmd.res_eq) begin
			found          <= 1'b1;
			y_result       <= ya_q[VW-1:0];
			y_result_valid <= ya_q[VW];
		end
		if (cmd.res_interp) begin
			found          <= 1'b1;
			y_result       <= neg_q ? (ya_q[VW-1:0] - quot_q[VW-1:0])
			                        : (ya_q[VW-1:0] + quot_q[VW-1:0]);
			y_result_valid <= 1'b1;
		end
	end

endmodule

/* sv/pltiu_ctrl.sv */
`include "assert_macros.svh"

module pltiu_ctrl #(
	parameter int TABLE_DEPTH = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [8:0]                      points_in_use,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            operation,
	input  logic [7:0]                      knot_index,
	output logic                            out_valid,
	input  logic                            out_ready,
	input  pltiu_pkg::sts_t                 sts,
	output pltiu_pkg::cmd_t                 cmd,
	output logic [$clog2(TABLE_DEPTH)-1:0]  rd_addr
);
	import pltiu_pkg::*;

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int CW  = AW + 1;
	localparam int DCW = $clog2(VALUE_WIDTH + 2);

	state_t         state_q, state_d;
	logic [CW-1:0]  n_q, n_w, idx_q, idx_nx;
	logic [DCW-1:0] cnt_q;
	logic           accept, is_query, idx_ok, bracket, last_seg;

	assign accept   = in_valid && in_ready;
	assign is_query = operation == OP_QUERY;
	assign idx_ok   = 32'(knot_index) < 32'(TABLE_DEPTH);
	assign n_w      = (32'(points_in_use) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
	                                                          : CW'(points_in_use);
	assign bracket  = sts.q_ge_xa && !sts.q_gt_rd;
	assign idx_nx   = idx_q + 1'b1;
	assign last_seg = idx_nx >= n_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_query)
					state_d = (n_w < CW'(2)) ? ST_OUT : ST_LAST_RD;
			end
			ST_LAST_RD:   state_d = ST_LAST_CHK;
			ST_LAST_CHK:  state_d = sts.q_gt_rd ? ST_OUT : ST_FIRST_RD;
			ST_FIRST_RD:  state_d = ST_FIRST_CHK;
			ST_FIRST_CHK: state_d = sts.q_lt_rd ? ST_OUT : ST_SCAN_RD;
			ST_SCAN_RD:   state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (bracket)       state_d = ST_YA_RD;
				else if (last_seg) state_d = ST_OUT;
				else               state_d = ST_SCAN_RD;
			end
			ST_YA_RD: state_d = ST_YB_RD;
			ST_YB_RD: state_d = ST_EVAL;
			ST_EVAL: begin
				if (sts.x_eq || !(sts.ya_ok && sts.yb_ok)) state_d = ST_OUT;
				else                                       state_d = ST_MUL;
			end
			ST_MUL:      state_d = ST_DIV_INIT;
			ST_DIV_INIT: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == DCW'(VALUE_WIDTH)) state_d = ST_FIN;
			end
			ST_FIN: state_d = ST_OUT;
			ST_OUT: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and datapath commands
	always_comb begin
		cmd       = '0;
		rd_addr   = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.wr       = in_valid && !is_query && idx_ok;
				cmd.cap_q    = in_valid && is_query;
				cmd.res_none = in_valid && is_query && (n_w < CW'(2));
			end
			ST_LAST_RD:   rd_addr = AW'(n_q - 1'b1);
			ST_LAST_CHK:  cmd.res_none = sts.q_gt_rd;
			ST_FIRST_RD:  rd_addr = '0;
			ST_FIRST_CHK: begin
				cmd.res_none = sts.q_lt_rd;
				cmd.ld_xa    = 1'b1;
			end
			ST_SCAN_RD:  rd_addr = idx_q[AW-1:0];
			ST_SCAN_CHK: begin
				cmd.ld_xb    = 1'b1;
				cmd.ld_xa    = !bracket;
				cmd.res_none = !bracket && last_seg;
			end
			ST_YA_RD: rd_addr = AW'(idx_q - 1'b1);
			ST_YB_RD: begin
				rd_addr    = idx_q[AW-1:0];
				cmd.ld_ya  = 1'b1;
			end
			ST_EVAL: begin
				cmd.res_eq   = sts.x_eq;
				cmd.res_none = !sts.x_eq && !(sts.ya_ok && sts.yb_ok);
				cmd.prep     = 1'b1;
			end
			ST_MUL:      cmd.mul = 1'b1;
			ST_DIV_INIT: cmd.div_init = 1'b1;
			ST_DIV:      cmd.div_step = 1'b1;
			ST_FIN:      cmd.res_interp = 1'b1;
			ST_OUT:      out_valid = 1'b1;
			default: ;
		endcase
	end

	// state, knot count, scan index and divide counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept && is_query) n_q <= n_w;
			if (state_q == ST_FIRST_CHK) idx_q <= CW'(1);
			if (state_q == ST_SCAN_CHK && !bracket) idx_q <= idx_nx;
			if (state_q == ST_DIV_INIT) cnt_q <= '0;
			if (state_q == ST_DIV) cnt_q <= cnt_q + 1'b1;
		end
	end

	`ASSERT_IMPL(a_one_item, clk, arst_n, in_ready, !out_valid)
	`ASSERT_IMPL(a_scan_bound, clk, arst_n, state_q == ST_SCAN_RD, (idx_q < n_q) && (idx_q != '0))
	`ASSERT_NEXT(a_query_busy, clk, arst_n, accept && is_query, state_q != ST_IDLE)
	`ASSERT_IMPL(a_div_bound, clk, arst_n, state_q == ST_DIV, cnt_q <= DCW'(VALUE_WIDTH))

endmodule
